// ===== rtl/sfla_pkg.sv =====
// ============================================================================
// sfla_pkg
// Shared types and codes for the slab free-list allocator: item structs,
// operation and status codes, sequencer states, and arithmetic unit controls.
// ============================================================================
package sfla_pkg;

    // Fixed field widths of the item channels
    localparam int OP_W    = 2;
    localparam int OFF_W   = 12;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 9;
    localparam int UNITS_W = 8;

    // Allocated count saturates at the top of its field
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Size register value after reset, in granules
    localparam logic [UNITS_W-1:0] UNITS_RESET = 8'd4;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
    localparam logic [OP_W-1:0] OP_REBUILD = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_FREE = 2'd2;

    // Input item
    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [OFF_W-1:0] object_offset;
    } t_sfla_in;

    // Result item
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [OFF_W-1:0]   result_offset;
        logic [COUNT_W-1:0] allocated_count;
        logic [COUNT_W-1:0] free_count;
    } t_sfla_out;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_FREE,
        S_REB_DIV,
        S_REB_FILL,
        S_DONE
    } t_state;

    // Shared arithmetic unit mode
    typedef enum logic [0:0] {
        AU_MUL,
        AU_DIV
    } t_au_mode;

    typedef struct packed {
        logic     start;
        t_au_mode mode;
    } t_au_ctl;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_au_sts;

endpackage

// ===== rtl/sfla_link_ram.sv =====
// ============================================================================
// sfla_link_ram
// Single-port next-link memory, one entry per slot, registered read data.
// ============================================================================
module sfla_link_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // Registered read, holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

// ===== rtl/sfla_arith.sv =====
// ============================================================================
// sfla_arith
// Shared shift/add unit: restoring divide one quotient bit per cycle, or
// shift-and-add multiply one multiplier bit per cycle, on a single adder.
// ============================================================================
module sfla_arith #(
    parameter int DVD_W  = 13,
    parameter int SIZE_W = 12,
    parameter int MUL_W  = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sfla_pkg::t_au_ctl            i_ctl,
    input  logic [DVD_W-1:0]             i_opa,   // dividend or multiplier
    input  logic [SIZE_W-1:0]            i_opb,   // divisor or multiplicand
    input  logic [sfla_pkg::OFF_W-1:0]   i_init,  // product start value
    output sfla_pkg::t_au_sts            o_sts,
    output logic [DVD_W-1:0]             o_quot,
    output logic [sfla_pkg::OFF_W-1:0]   o_prod
);

    localparam int RES_W = sfla_pkg::OFF_W;
    localparam int AU_W  = (RES_W > SIZE_W + 1) ? RES_W : SIZE_W + 1;
    localparam int STEPS = (DVD_W > MUL_W) ? DVD_W : MUL_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic                r_busy;
    logic                r_done;
    sfla_pkg::t_au_mode  r_mode;
    logic [CNT_W-1:0]    r_cnt;
    logic [DVD_W-1:0]    r_dvd;
    logic [AU_W-1:0]     r_acc;
    logic [AU_W-1:0]     r_opb;

    logic                is_div;
    logic [AU_W-1:0]     shifted;
    logic [AU_W-1:0]     add_a;
    logic [AU_W-1:0]     add_b;
    logic [AU_W:0]       sum;

    // The one adder, shared by both modes
    assign is_div  = (r_mode == sfla_pkg::AU_DIV);
    assign shifted = {r_acc[AU_W-2:0], r_dvd[DVD_W-1]};
    assign add_a   = is_div ? shifted : r_acc;
    assign add_b   = is_div ? ~r_opb : (r_dvd[0] ? r_opb : '0);
    assign sum     = {1'b0, add_a} + {1'b0, add_b} + (AU_W+1)'(is_div);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_ctl.mode == sfla_pkg::AU_DIV) ? CNT_W'(DVD_W) : CNT_W'(MUL_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_mode <= i_ctl.mode;
            r_dvd  <= i_opa;
            r_opb  <= AU_W'(i_opb);
            r_acc  <= (i_ctl.mode == sfla_pkg::AU_DIV) ? '0 : AU_W'(i_init);
        end else if (r_busy) begin
            if (is_div) begin
                r_acc <= sum[AU_W] ? sum[AU_W-1:0] : shifted;
                r_dvd <= {r_dvd[DVD_W-2:0], sum[AU_W]};
            end else begin
                r_acc <= sum[AU_W-1:0];
                r_opb <= {r_opb[AU_W-2:0], 1'b0};
                r_dvd <= {1'b0, r_dvd[DVD_W-1:1]};
            end
        end
    end

    assign o_sts.done     = r_done;
    assign o_sts.rem_zero = (r_acc == '0);
    assign o_quot         = r_dvd;
    assign o_prod         = r_acc[RES_W-1:0];

endmodule

// ===== rtl/slab_free_list_allocator_unit.sv =====
// ============================================================================
// slab_free_list_allocator_unit
// LIFO free list of fixed-size slots in one page, with a link per slot.
// Allocate pops, free pushes after an offset check, rebuild recarves the page.
// ============================================================================
//
//  Channel   Direction  Signals                          Handshake
//  in        input      i_in_item (t_sfla_in)            i_in_valid / o_in_ready
//  out       output     o_out_item (t_sfla_out)          o_out_valid / i_out_ready
//  cfg       input      i_cfg_wdata (object size units)  i_cfg_we, no wait
//
//  Allocate and free use the shared shift/add unit (one bit a cycle);
//  rebuild divides on it as well, then fills links through the one
//  link-memory write port (one slot a cycle).
//  Reset is synchronous, active low; the link memory needs no clearing pass.
//  One item is in work at a time; a finished result waits in the output
//  register and the next item is taken meanwhile, stalling only at its end.
// ============================================================================
module slab_free_list_allocator_unit #(
    parameter int PAGE_BYTES    = 4096,
    parameter int HEADER_BYTES  = 64,
    parameter int GRANULE_BYTES = 16,
    parameter int MAX_SLOTS     = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  sfla_pkg::t_sfla_in                 i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output sfla_pkg::t_sfla_out                o_out_item,
    input  logic                               i_cfg_we,
    input  logic [sfla_pkg::UNITS_W-1:0]       i_cfg_wdata
);

    localparam int OFF_W   = sfla_pkg::OFF_W;
    localparam int COUNT_W = sfla_pkg::COUNT_W;
    localparam int UNITS_W = sfla_pkg::UNITS_W;
    localparam int IDX_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SLOT_W  = $clog2(MAX_SLOTS + 1);
    localparam int SIZE_W  = $clog2(255 * GRANULE_BYTES + 1);
    localparam int PG_W    = $clog2(PAGE_BYTES + 1);
    localparam int DVD_W   = (PG_W > OFF_W) ? PG_W : OFF_W;
    localparam int CMP_W   = (DVD_W > SLOT_W) ? DVD_W : SLOT_W;
    localparam int CNT_W   = (SLOT_W > COUNT_W) ? SLOT_W : COUNT_W;
    localparam int SPAN    = (PAGE_BYTES > HEADER_BYTES) ? PAGE_BYTES - HEADER_BYTES : 0;
    localparam logic [SLOT_W-1:0] END_MARK = SLOT_W'(MAX_SLOTS);

    // Registers
    sfla_pkg::t_state              r_state, n_state;
    logic [UNITS_W-1:0]            r_cfg_units;
    logic [SIZE_W-1:0]             r_size, n_size;
    logic [SLOT_W-1:0]             r_head, n_head;
    logic [COUNT_W-1:0]            r_alloc, n_alloc;
    logic [SLOT_W-1:0]             r_built, n_built;
    logic [SLOT_W-1:0]             r_idx, n_idx;
    logic [sfla_pkg::STAT_W-1:0]   r_status, n_status;
    logic [OFF_W-1:0]              r_result, n_result;
    logic                          r_out_valid, n_out_valid;
    sfla_pkg::t_sfla_out           r_out_item, n_out_item;

    // Datapath wires
    logic [UNITS_W-1:0]            eff_units;
    logic [SIZE_W-1:0]             new_size;
    logic [DVD_W-1:0]              off_ext;
    logic [DVD_W-1:0]              rel;
    logic                          below_hdr;
    logic [CNT_W-1:0]              free_cnt;
    logic [SLOT_W-1:0]             clip_cnt;

    // Submodule connections
    sfla_pkg::t_au_ctl             au_ctl;
    sfla_pkg::t_au_sts             au_sts;
    logic [DVD_W-1:0]              au_opa;
    logic [SIZE_W-1:0]             au_opb;
    logic [DVD_W-1:0]              au_quot;
    logic [OFF_W-1:0]              au_prod;
    logic                          mem_we, mem_re;
    logic [IDX_W-1:0]              mem_addr;
    logic [SLOT_W-1:0]             mem_wdata, mem_rdata;

    sfla_arith #(
        .DVD_W  (DVD_W),
        .SIZE_W (SIZE_W),
        .MUL_W  (IDX_W)
    ) u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (au_ctl),
        .i_opa   (au_opa),
        .i_opb   (au_opb),
        .i_init  (OFF_W'(HEADER_BYTES)),
        .o_sts   (au_sts),
        .o_quot  (au_quot),
        .o_prod  (au_prod)
    );

    sfla_link_ram #(
        .DEPTH (MAX_SLOTS),
        .AW    (IDX_W),
        .DW    (SLOT_W)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_units <= sfla_pkg::UNITS_RESET;
        end else if (i_cfg_we) begin
            r_cfg_units <= i_cfg_wdata;
        end
    end

    // Size and offset helpers
    assign eff_units = (r_cfg_units == '0) ? UNITS_W'(1) : r_cfg_units;
    assign new_size  = SIZE_W'(32'(eff_units) * 32'(GRANULE_BYTES));
    assign off_ext   = DVD_W'(i_in_item.object_offset);
    assign below_hdr = (off_ext < DVD_W'(HEADER_BYTES));
    assign rel       = off_ext - DVD_W'(HEADER_BYTES);
    assign clip_cnt  = (CMP_W'(au_quot) > CMP_W'(MAX_SLOTS)) ? END_MARK : SLOT_W'(au_quot);
    assign free_cnt  = (CNT_W'(r_built) > CNT_W'(r_alloc))
                     ? CNT_W'(r_built) - CNT_W'(r_alloc) : '0;

    // Sequencer: next state and datapath controls
    always_comb begin
        n_state     = r_state;
        n_size      = r_size;
        n_head      = r_head;
        n_alloc     = r_alloc;
        n_built     = r_built;
        n_idx       = r_idx;
        n_status    = r_status;
        n_result    = r_result;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        o_in_ready  = 1'b0;
        au_ctl.start = 1'b0;
        au_ctl.mode  = sfla_pkg::AU_DIV;
        au_opa      = rel;
        au_opb      = r_size;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = r_head[IDX_W-1:0];
        mem_wdata   = r_head;

        // Output register drains independently
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            sfla_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                n_status   = sfla_pkg::ST_OK;
                n_result   = '0;
                if (i_in_valid) begin
                    unique case (i_in_item.operation)
                        sfla_pkg::OP_ALLOC: begin
                            if (r_head >= END_MARK) begin
                                n_status = sfla_pkg::ST_EMPTY;
                                n_state  = sfla_pkg::S_DONE;
                            end else begin
                                // Product HEADER + head * size, link read at head
                                au_ctl.start = 1'b1;
                                au_ctl.mode  = sfla_pkg::AU_MUL;
                                au_opa       = DVD_W'(r_head[IDX_W-1:0]);
                                mem_re       = 1'b1;
                                n_state      = sfla_pkg::S_ALLOC;
                            end
                        end
                        sfla_pkg::OP_FREE: begin
                            if (below_hdr) begin
                                n_status = sfla_pkg::ST_BAD_FREE;
                                n_state  = sfla_pkg::S_DONE;
                            end else begin
                                au_ctl.start = 1'b1;
                                n_state      = sfla_pkg::S_FREE;
                            end
                        end
                        sfla_pkg::OP_REBUILD: begin
                            // Slot count = span / new size
                            n_size       = new_size;
                            au_ctl.start = 1'b1;
                            au_opa       = DVD_W'(SPAN);
                            au_opb       = new_size;
                            n_state      = sfla_pkg::S_REB_DIV;
                        end
                        sfla_pkg::OP_NOP: begin
                            n_state = sfla_pkg::S_DONE;
                        end
                        default: begin
                            n_state = sfla_pkg::S_DONE;
                        end
                    endcase
                end
            end

            sfla_pkg::S_ALLOC: begin
                if (au_sts.done) begin
                    n_result = au_prod;
                    n_head   = mem_rdata;
                    if (r_alloc != sfla_pkg::COUNT_MAX) begin
                        n_alloc = r_alloc + COUNT_W'(1);
                    end
                    n_state = sfla_pkg::S_DONE;
                end
            end

            sfla_pkg::S_FREE: begin
                if (au_sts.done) begin
                    if (!au_sts.rem_zero || (CMP_W'(au_quot) >= CMP_W'(r_built))) begin
                        n_status = sfla_pkg::ST_BAD_FREE;
                    end else begin
                        // Push slot: link to old head
                        mem_we    = 1'b1;
                        mem_addr  = au_quot[IDX_W-1:0];
                        mem_wdata = r_head;
                        n_head    = SLOT_W'(au_quot);
                        if (r_alloc != '0) begin
                            n_alloc = r_alloc - COUNT_W'(1);
                        end
                    end
                    n_state = sfla_pkg::S_DONE;
                end
            end

            sfla_pkg::S_REB_DIV: begin
                if (au_sts.done) begin
                    n_built = clip_cnt;
                    n_idx   = '0;
                    n_state = sfla_pkg::S_REB_FILL;
                end
            end

            sfla_pkg::S_REB_FILL: begin
                // One link a cycle, slot i points at slot i-1, slot 0 at the end mark
                if (r_idx == r_built) begin
                    n_head  = (r_built == '0) ? END_MARK : r_built - SLOT_W'(1);
                    n_alloc = '0;
                    n_state = sfla_pkg::S_DONE;
                end else begin
                    mem_we    = 1'b1;
                    mem_addr  = r_idx[IDX_W-1:0];
                    mem_wdata = (r_idx == '0) ? END_MARK : r_idx - SLOT_W'(1);
                    n_idx     = r_idx + SLOT_W'(1);
                end
            end

            sfla_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid                = 1'b1;
                    n_out_item.status          = r_status;
                    n_out_item.result_offset   = r_result;
                    n_out_item.allocated_count = r_alloc;
                    n_out_item.free_count      = free_cnt[COUNT_W-1:0];
                    n_state                    = sfla_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = sfla_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sfla_pkg::S_IDLE;
            r_size      <= SIZE_W'(32'(sfla_pkg::UNITS_RESET) * 32'(GRANULE_BYTES));
            r_head      <= END_MARK;
            r_alloc     <= '0;
            r_built     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_head      <= n_head;
            r_alloc     <= n_alloc;
            r_built     <= n_built;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_status   <= n_status;
        r_result   <= n_result;
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
